// ===== sv/lgs_pkg.sv =====
`timescale 1ns / 1ps

package lgs_pkg;

    localparam int GRID_COLS_DEF = 64;
    localparam int GRID_ROWS_DEF = 64;

    localparam int DIM_W     = 7;
    localparam int COUNT_W   = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0]   DIM_RESET = 7'd64;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] col;
        logic [5:0] row;
        logic       cell_value;
    } cmd_t;

    typedef struct packed {
        logic               kind;
        logic               cell_alive;
        logic [COUNT_W-1:0] changed_count;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CELL,
        ST_STEP,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic pending;
        logic [COUNT_W-1:0] total;
    } acc_status_t;

endpackage

// ===== sv/lgs_grid_mem.sv =====
`timescale 1ns / 1ps

module lgs_grid_mem
    import lgs_pkg::*;
#(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [$clog2(GRID_ROWS)-1:0] rd_addr,
    output logic [GRID_COLS-1:0]         rd_data,
    input  logic                         wr_en,
    input  logic [$clog2(GRID_ROWS)-1:0] wr_addr,
    input  logic [GRID_COLS-1:0]         wr_data
);

    logic [GRID_COLS-1:0] mem [GRID_ROWS];
    logic [GRID_COLS-1:0] q_reg;
    logic [GRID_ROWS-1:0] valid_reg;
    logic                 rvld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    // row valid bits stand in for clearing the array at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rvld_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvld_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rvld_reg ? q_reg : '0;

endmodule

// ===== sv/lgs_row_calc.sv =====
`timescale 1ns / 1ps

module lgs_row_calc
    import lgs_pkg::*;
#(
    parameter int GRID_COLS = GRID_COLS_DEF
) (
    input  logic [GRID_COLS-1:0] prev_row,
    input  logic [GRID_COLS-1:0] cur_row,
    input  logic [GRID_COLS-1:0] next_row,
    input  logic [GRID_COLS-1:0] col_mask,
    output logic [GRID_COLS-1:0] new_row,
    output logic [GRID_COLS-1:0] flips
);

    logic [GRID_COLS+1:0] p_pad;
    logic [GRID_COLS+1:0] c_pad;
    logic [GRID_COLS+1:0] n_pad;

    assign p_pad = {1'b0, prev_row & col_mask, 1'b0};
    assign c_pad = {1'b0, cur_row & col_mask, 1'b0};
    assign n_pad = {1'b0, next_row & col_mask, 1'b0};

    always_comb
    begin
        logic [3:0] n;
        logic       rule;
        for (int j = 0; j < GRID_COLS; j++)
        begin
            n = 4'(p_pad[j]) + 4'(p_pad[j+1]) + 4'(p_pad[j+2])
              + 4'(c_pad[j]) + 4'(c_pad[j+2])
              + 4'(n_pad[j]) + 4'(n_pad[j+1]) + 4'(n_pad[j+2]);
            rule = (n == 4'd3) || (cur_row[j] && (n == 4'd2));
            new_row[j] = col_mask[j] ? rule : cur_row[j];
        end
    end

    assign flips = new_row ^ cur_row;

endmodule

// ===== sv/lgs_flip_acc.sv =====
`timescale 1ns / 1ps

module lgs_flip_acc
    import lgs_pkg::*;
#(
    parameter int GRID_COLS = GRID_COLS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 in_en,
    input  logic [GRID_COLS-1:0] in_flips,
    output acc_status_t          status
);

    localparam int GRP   = 16;
    localparam int NG    = (GRID_COLS + GRP - 1) / GRP;
    localparam int PW    = NG * GRP;
    localparam int GW    = $clog2(GRP + 1);
    localparam int SW    = $clog2(GRID_COLS + 1);

    logic [GRID_COLS-1:0] flip_reg;
    logic                 v1_reg;
    logic [GW-1:0]        grp_reg [NG];
    logic [GW-1:0]        grp_next [NG];
    logic                 v2_reg;
    logic [COUNT_W-1:0]   acc_reg;
    logic [COUNT_W-1:0]   acc_next;
    logic [PW-1:0]        flip_pad;
    logic [SW-1:0]        grp_sum;
    logic [COUNT_W:0]     sum_wide;

    assign flip_pad = PW'(flip_reg);

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_next[g] = '0;
            for (int b = 0; b < GRP; b++)
            begin
                grp_next[g] = grp_next[g] + GW'(flip_pad[g*GRP+b]);
            end
        end
    end

    always_comb
    begin
        grp_sum = '0;
        for (int g = 0; g < NG; g++)
        begin
            grp_sum = grp_sum + SW'(grp_reg[g]);
        end
        sum_wide = (COUNT_W+1)'(acc_reg) + (COUNT_W+1)'(grp_sum);
        acc_next = (sum_wide > (COUNT_W+1)'(COUNT_MAX)) ? COUNT_MAX : sum_wide[COUNT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (in_en)
        begin
            flip_reg <= in_flips;
        end
        if (v1_reg)
        begin
            grp_reg <= grp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else if (clear)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            v1_reg <= in_en;
            v2_reg <= v1_reg;
            if (v2_reg)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    assign status.pending = v1_reg | v2_reg;
    assign status.total   = acc_reg;

endmodule

// ===== sv/life_grid_generation_step.sv =====
`timescale 1ns / 1ps

// Channel   Ports                               Handshake
// -------   ---------------------------------   ----------------------------------
// item in   cmd (op, col, row, cell_value)      taken when start && !busy
// result    result (kind, cell_alive, count)    one cycle, marked by done
// config    cfg_wr_en, cfg_index, cfg_wdata     written when cfg_wr_en is high
//
// Write and read go through a row read, then a write back or a result.
// Step reads one grid row and writes one row back per cycle through the
// single-port-per-direction row memory, plus a flip count pipeline (flip
// register, group counts, accumulator). Reset clears the grid through
// per-row valid bits. Results cannot be stalled; done pulses for one cycle.

module life_grid_generation_step
    import lgs_pkg::*;
#(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cmd_t                 cmd,
    output logic                 done,
    output result_t              result,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_wdata
);

    localparam int RowW = $clog2(GRID_ROWS);
    localparam int ColW = $clog2(GRID_COLS);
    localparam int NrW  = $clog2(GRID_ROWS + 1);
    localparam int NcW  = $clog2(GRID_COLS + 1);
    localparam int TW   = $clog2(GRID_ROWS + 2);
    localparam int MaxN = (NrW > NcW) ? NrW : NcW;
    localparam int DimW = (MaxN > DIM_W) ? MaxN : DIM_W;

    state_t state_reg;
    state_t state_next;

    logic [DIM_W-1:0] grid_width_reg;
    logic [DIM_W-1:0] grid_height_reg;
    logic [NcW-1:0]   nc;
    logic [NrW-1:0]   nr;

    logic [ColW-1:0] col_idx_reg;
    logic [RowW-1:0] row_idx_reg;
    logic            val_reg;
    logic            inside_reg;
    logic            is_read_reg;
    logic [DimW-1:0] col_ext;
    logic [DimW-1:0] row_ext;
    logic            in_area;

    logic [TW-1:0]        t_reg;
    logic [TW-1:0]        t_wr;
    logic [GRID_COLS-1:0] prev_reg;
    logic [GRID_COLS-1:0] cur_reg;
    logic [GRID_COLS-1:0] nxt_row;
    logic [GRID_COLS-1:0] col_mask;
    logic [GRID_COLS-1:0] new_row;
    logic [GRID_COLS-1:0] flips;
    logic [GRID_COLS-1:0] cell_row;

    logic                 mem_rd_en;
    logic [RowW-1:0]      mem_rd_addr;
    logic [GRID_COLS-1:0] mem_rd_data;
    logic                 mem_wr_en;
    logic [RowW-1:0]      mem_wr_addr;
    logic [GRID_COLS-1:0] mem_wr_data;

    logic        accept;
    logic        step_go;
    logic        step_last;
    logic        compute_en;
    logic        acc_clear;
    logic        res_load;
    result_t     res_value;
    acc_status_t acc_status;
    logic        done_reg;
    result_t     result_reg;

    assign accept  = start && (state_reg == ST_IDLE);
    assign busy    = (state_reg != ST_IDLE);

    assign nc = (DimW'(grid_width_reg) > DimW'(GRID_COLS))
              ? NcW'(GRID_COLS) : NcW'(grid_width_reg);
    assign nr = (DimW'(grid_height_reg) > DimW'(GRID_ROWS))
              ? NrW'(GRID_ROWS) : NrW'(grid_height_reg);

    assign col_ext = DimW'(cmd.col);
    assign row_ext = DimW'(cmd.row);
    assign in_area = (col_ext < DimW'(nc)) && (row_ext < DimW'(nr));

    always_comb
    begin
        for (int j = 0; j < GRID_COLS; j++)
        begin
            col_mask[j] = NcW'(j) < nc;
        end
    end

    assign t_wr      = t_reg - TW'(2);
    assign step_last = (t_reg == TW'(nr) + TW'(1));
    assign nxt_row   = (t_reg <= TW'(nr)) ? mem_rd_data : '0;

    always_comb
    begin
        cell_row              = mem_rd_data;
        cell_row[col_idx_reg] = val_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && ((cmd.op == OP_READ) || (cmd.op == OP_WRITE)))
                begin
                    state_next = ST_CELL;
                end
                else if (accept && (cmd.op == OP_STEP))
                begin
                    state_next = ST_STEP;
                end
            end
            ST_CELL:
            begin
                state_next = ST_IDLE;
            end
            ST_STEP:
            begin
                if (step_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!acc_status.pending)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = row_ext[RowW-1:0];
        mem_wr_en   = 1'b0;
        mem_wr_addr = row_idx_reg;
        mem_wr_data = cell_row;
        step_go     = 1'b0;
        compute_en  = 1'b0;
        acc_clear   = 1'b0;
        res_load    = 1'b0;
        res_value   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                mem_rd_en = accept && in_area
                          && ((cmd.op == OP_READ) || (cmd.op == OP_WRITE));
                step_go   = accept && (cmd.op == OP_STEP);
                acc_clear = step_go;
            end
            ST_CELL:
            begin
                mem_wr_en = !is_read_reg && inside_reg;
                res_load  = is_read_reg;
                res_value.kind       = KIND_READ;
                res_value.cell_alive = inside_reg && mem_rd_data[col_idx_reg];
            end
            ST_STEP:
            begin
                mem_rd_en   = t_reg < TW'(nr);
                mem_rd_addr = t_reg[RowW-1:0];
                compute_en  = t_reg >= TW'(2);
                mem_wr_en   = compute_en;
                mem_wr_addr = t_wr[RowW-1:0];
                mem_wr_data = new_row;
            end
            ST_DRAIN:
            begin
                res_load  = !acc_status.pending;
                res_value.kind          = KIND_STEP;
                res_value.changed_count = acc_status.total;
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            grid_width_reg  <= DIM_RESET;
            grid_height_reg <= DIM_RESET;
            done_reg        <= 1'b0;
            t_reg           <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= res_load;
            if (cfg_wr_en && (cfg_index == CFG_GRID_WIDTH))
            begin
                grid_width_reg <= cfg_wdata;
            end
            if (cfg_wr_en && (cfg_index == CFG_GRID_HEIGHT))
            begin
                grid_height_reg <= cfg_wdata;
            end
            if (step_go)
            begin
                t_reg <= '0;
            end
            else if (state_reg == ST_STEP)
            begin
                t_reg <= t_reg + TW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_idx_reg <= col_ext[ColW-1:0];
            row_idx_reg <= row_ext[RowW-1:0];
            val_reg     <= cmd.cell_value;
            inside_reg  <= in_area;
            is_read_reg <= (cmd.op == OP_READ);
        end
        if (step_go)
        begin
            cur_reg <= '0;
        end
        else if ((state_reg == ST_STEP) && (t_reg != '0))
        begin
            prev_reg <= cur_reg;
            cur_reg  <= nxt_row;
        end
        if (res_load)
        begin
            result_reg <= res_value;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    lgs_grid_mem #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    lgs_row_calc #(
        .GRID_COLS (GRID_COLS)
    ) u_calc (
        .prev_row (prev_reg),
        .cur_row  (cur_reg),
        .next_row (nxt_row),
        .col_mask (col_mask),
        .new_row  (new_row),
        .flips    (flips)
    );

    lgs_flip_acc #(
        .GRID_COLS (GRID_COLS)
    ) u_acc (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (acc_clear),
        .in_en    (compute_en),
        .in_flips (flips),
        .status   (acc_status)
    );

`ifndef SYNTHESIS
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_CELL) || ($past(state_reg) == ST_DRAIN))
        else $error("result strobe without a finishing read or step");

    a_no_row_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) && mem_rd_en && mem_wr_en |-> mem_rd_addr != mem_wr_addr)
        else $error("step reads and writes the same row in one cycle");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && ((cmd.op == OP_READ) || (cmd.op == OP_STEP)) |=> busy)
        else $error("read or step item accepted but block not busy");
`endif

endmodule

// ===== tb/life_grid_generation_step_tb.sv =====
`timescale 1ns / 1ps

module life_grid_generation_step_tb;
    import lgs_pkg::*;

    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int SETTLE_CYCLES = 10;
    localparam int TAIL_CYCLES   = 80;
    localparam int PHASE_COUNT   = 13;
    localparam int PHASE_ITEMS   = 128;

    localparam logic [1:0]           OP_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    cmd_t                 cmd       = '0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_wdata = '0;
    logic                 busy;
    logic                 done;
    result_t              result;

    // mirror of the grid and of the area registers
    bit               life_cells [GRID_ROWS_DEF][GRID_COLS_DEF];
    logic [DIM_W-1:0] area_cols = DIM_RESET;
    logic [DIM_W-1:0] area_rows = DIM_RESET;

    result_t pending_results[$];
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    int      sent_items     = 0;
    int      reads_checked  = 0;
    int      steps_checked  = 0;
    int      areas_used     = 0;
    bit      steady_sender  = 1'b0;

    life_grid_generation_step u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int active_cols();
        return (area_cols > GRID_COLS_DEF) ? GRID_COLS_DEF : int'(area_cols);
    endfunction

    function automatic int active_rows();
        return (area_rows > GRID_ROWS_DEF) ? GRID_ROWS_DEF : int'(area_rows);
    endfunction

    // B3/S23, no wrap; cells outside the area are neither updated nor counted
    function automatic result_t advance_generation();
        bit      next_gen [GRID_ROWS_DEF][GRID_COLS_DEF];
        int      cols;
        int      rows;
        int      flips;
        int      live;
        int      rr;
        int      cc;
        result_t res;
        cols  = active_cols();
        rows  = active_rows();
        flips = 0;
        for (int r = 0; r < rows; r++)
        begin
            for (int c = 0; c < cols; c++)
            begin
                live = 0;
                for (int dr = -1; dr <= 1; dr++)
                begin
                    for (int dc = -1; dc <= 1; dc++)
                    begin
                        rr = r + dr;
                        cc = c + dc;
                        if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 &&
                            rr < rows && cc < cols)
                            live += life_cells[rr][cc];
                    end
                end
                next_gen[r][c] = life_cells[r][c] ? (live == 2 || live == 3) : (live == 3);
                if (next_gen[r][c] != life_cells[r][c])
                    flips++;
            end
        end
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++)
                life_cells[r][c] = next_gen[r][c];
        res.kind          = KIND_STEP;
        res.cell_alive    = 1'b0;
        res.changed_count = (flips > COUNT_MAX) ? COUNT_MAX : flips[COUNT_W-1:0];
        return res;
    endfunction

    function automatic void predict_item(input cmd_t c);
        int      cols;
        int      rows;
        bit      in_area;
        result_t res;
        cols    = active_cols();
        rows    = active_rows();
        in_area = (c.col < cols) && (c.row < rows);
        case (c.op)
            OP_WRITE:
            begin
                if (in_area)
                    life_cells[c.row][c.col] = c.cell_value;
            end
            OP_READ:
            begin
                res.kind          = KIND_READ;
                res.cell_alive    = in_area ? life_cells[c.row][c.col] : 1'b0;
                res.changed_count = '0;
                pending_results.push_back(res);
            end
            OP_STEP:
                pending_results.push_back(advance_generation());
            default: ;
        endcase
        sent_items++;
    endfunction

    function automatic cmd_t make_cmd(input logic [1:0] op, input int col, input int row,
                                      input bit val);
        cmd_t c;
        c.op         = op;
        c.col        = col[5:0];
        c.row        = row[5:0];
        c.cell_value = val;
        return c;
    endfunction

    // coordinate within two of center, clamped into the area; any coordinate if the area is empty
    function automatic int near(input int center, input int span);
        int v;
        if (span == 0)
            return $urandom_range(0, 63);
        v = center + $urandom_range(0, 4) - 2;
        if (v < 0)
            v = 0;
        if (v >= span)
            v = span - 1;
        return v;
    endfunction

    function automatic void check_field(input string name, input logic [COUNT_W-1:0] want,
                                        input logic [COUNT_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, result);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", COUNT_W'(want.kind), COUNT_W'(result.kind));
                check_field("cell_alive", COUNT_W'(want.cell_alive),
                            COUNT_W'(result.cell_alive));
                check_field("changed_count", want.changed_count, result.changed_count);
                if (want.kind == KIND_READ)
                    reads_checked++;
                else
                    steps_checked++;
            end
        end
    end

    task automatic send_item(input cmd_t c);
        if (!steady_sender && $urandom_range(0, 99) < 7)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        predict_item(c);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // writes can finish after the last read or step result, so give them time
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_wr_en <= 1'b1;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_GRID_WIDTH)
            area_cols = val;
        else if (idx == CFG_GRID_HEIGHT)
            area_rows = val;
    endtask

    task automatic test_reset_state();
        send_item(make_cmd(OP_READ, 0, 0, 1'b0));
        send_item(make_cmd(OP_READ, 63, 63, 1'b0));
        send_item(make_cmd(OP_READ, 17, 42, 1'b1));
    endtask

    task automatic test_cell_access();
        send_item(make_cmd(OP_WRITE, 0, 0, 1'b1));
        send_item(make_cmd(OP_WRITE, 63, 63, 1'b1));
        send_item(make_cmd(OP_READ, 0, 0, 1'b0));
        send_item(make_cmd(OP_READ, 63, 63, 1'b1));
        send_item(make_cmd(OP_UNUSED, 63, 0, 1'b1));
        send_item(make_cmd(OP_STEP, 0, 0, 1'b0));
        send_item(make_cmd(OP_READ, 63, 63, 1'b0));
    endtask

    task automatic test_blinker();
        for (int c = 20; c <= 22; c++)
            send_item(make_cmd(OP_WRITE, c, 10, 1'b1));
        send_item(make_cmd(OP_STEP, 0, 0, 1'b0));
        send_item(make_cmd(OP_READ, 21, 9, 1'b0));
        send_item(make_cmd(OP_STEP, 63, 63, 1'b1));
    endtask

    task automatic test_area_limits();
        // empty area: writes dropped, reads zero, step flips nothing
        write_reg(CFG_GRID_WIDTH, 7'd0);
        send_item(make_cmd(OP_WRITE, 5, 5, 1'b1));
        send_item(make_cmd(OP_READ, 21, 10, 1'b0));
        send_item(make_cmd(OP_STEP, 0, 0, 1'b0));
        // oversized area clamps to the stored grid; spare indexes do nothing
        write_reg(CFG_GRID_WIDTH, 7'd127);
        write_reg(CFG_GRID_HEIGHT, 7'd127);
        write_reg(CFG_SPARE_LO, 7'd5);
        write_reg(CFG_SPARE_HI, 7'd2);
        send_item(make_cmd(OP_READ, 21, 10, 1'b0));
        send_item(make_cmd(OP_STEP, 0, 0, 1'b0));
        areas_used += 2;
    endtask

    task automatic run_phase(input bit pause_midway);
        int goal;
        int cols;
        int rows;
        int center_c;
        int center_r;
        goal = sent_items + PHASE_ITEMS;
        cols = active_cols();
        rows = active_rows();
        while (sent_items < goal)
        begin
            if (pause_midway && sent_items >= goal - PHASE_ITEMS / 2)
            begin
                drain_results();
                pause_midway = 1'b0;
            end
            if ($urandom_range(0, 99) < 75)
            begin
                // seed a small cluster, run it a few generations, probe it
                center_c = (cols == 0) ? 0 : $urandom_range(0, cols - 1);
                center_r = (rows == 0) ? 0 : $urandom_range(0, rows - 1);
                repeat ($urandom_range(1, 12))
                    send_item(make_cmd(OP_WRITE, near(center_c, cols), near(center_r, rows),
                                       $urandom_range(0, 99) < 70));
                repeat ($urandom_range(1, 3))
                begin
                    send_item(make_cmd(OP_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                                       1'($urandom_range(0, 1))));
                    repeat ($urandom_range(0, 2))
                        send_item(make_cmd(OP_READ, near(center_c, cols),
                                           near(center_r, rows),
                                           1'($urandom_range(0, 1))));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_item(make_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 63),
                                       $urandom_range(0, 63), 1'($urandom_range(0, 1))));
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:       begin w = 7'd1;   h = 7'd1;   end
                1:       begin w = 7'd64;  h = 7'd1;   end
                2:       begin w = 7'd1;   h = 7'd64;  end
                3:       begin w = 7'd3;   h = 7'd3;   end
                4:       begin w = 7'd8;   h = 7'd8;   end
                5:       begin w = 7'd127; h = 7'd5;   end
                6:       begin w = 7'd65;  h = 7'd127; end
                7:       begin w = 7'd0;   h = 7'd12;  end
                8:       begin w = 7'd12;  h = 7'd0;   end
                9:       begin w = 7'd16;  h = 7'd16;  end
                10:      begin w = 7'd2;   h = 7'd40;  end
                11:      begin w = 7'd64;  h = 7'd64;  end
                default:
                begin
                    w = 7'($urandom_range(1, 64));
                    h = 7'($urandom_range(1, 64));
                end
            endcase
            write_reg(CFG_GRID_WIDTH, w);
            write_reg(CFG_GRID_HEIGHT, h);
            areas_used++;
            steady_sender = (p == 4);
            run_phase(p == 9);
        end
        steady_sender = 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_cell_access();
        test_blinker();
        test_area_limits();
        test_random_traffic();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Checked %0d cell reads and %0d generation steps from %0d items",
                 reads_checked, steps_checked, sent_items);
        $display("across %0d area settings, from empty and 1x1 up to clamped oversize",
                 areas_used);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== life_grid_generation_step.f =====
sv/lgs_pkg.sv
sv/lgs_grid_mem.sv
sv/lgs_row_calc.sv
sv/lgs_flip_acc.sv
sv/life_grid_generation_step.sv
tb/life_grid_generation_step_tb.sv
